// File: hdl/nal_eps_pkg.sv
// ----------------------------------------------------------------------------
// NAL emulation prevention strip: shared definitions
// Result kinds and the compact result bundle passed from the byte parser to
// the output buffer.
// ----------------------------------------------------------------------------
package nal_eps_pkg;

	localparam logic [1:0] KIND_BYTE   = 2'd0;
	localparam logic [1:0] KIND_END    = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;

	localparam logic [7:0] EP_BYTE = 8'd3;

	// The words caused by one input byte always come in this order: some
	// held zero bytes, then possibly the byte itself, then possibly an end
	// or reject word.
	typedef struct packed {
		logic [1:0]  zeros;
		logic        byte_v;
		logic [7:0]  data;
		logic        tail_v;
		logic [1:0]  tail_kind;
		logic [15:0] count;
	} nal_eps_res_t;

endpackage

// File: hdl/nal_emulation_prevention_strip.sv
// ----------------------------------------------------------------------------
// NAL emulation prevention strip
// Length-checks one length-prefixed NAL per packet and strips its emulation
// prevention bytes.
// ----------------------------------------------------------------------------
// A byte is taken in every cycle as long as each byte gives at most one output
// word and m_tready stays high. A byte that gives more words (held zeros
// flushed together with the byte and an end word, up to four in all) holds the
// input until its last word is taken, since the output buffer hands out one
// word per cycle while m_tready is high; bytes that give no word never stall.
// Output kind 0 carries a payload byte, kind 1 the byte count at the end of the
// NAL, kind 2 a rejected length; tlast marks the last word from one input byte.
module nal_emulation_prevention_strip (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // in_byte[7:0], packet_size[24:8], zero pad
	input  logic        s_tuser,   // first_of_packet
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // out_byte[7:0], byte_count[23:8]
	output logic [1:0]  m_tuser,   // kind[1:0]
	output logic        m_tlast
);

	nal_eps_pkg::nal_eps_res_t res;
	logic                      accept;

	assign accept = s_tvalid && s_tready;

	nal_eps_parser u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.in_byte         (s_tdata[7:0]),
		.first_of_packet (s_tuser),
		.packet_size     (s_tdata[24:8]),
		.res             (res)
	);

	nal_eps_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.res      (res),
		.ready    (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// File: hdl/nal_eps_parser.sv
// ----------------------------------------------------------------------------
// NAL emulation prevention strip: byte parser
// Holds the packet and NAL state and turns each accepted byte into a result
// bundle in a single pass.
// ----------------------------------------------------------------------------
module nal_eps_parser (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [7:0]                 in_byte,
	input  logic                       first_of_packet,
	input  logic [16:0]                packet_size,
	output nal_eps_pkg::nal_eps_res_t  res
);

	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_LEN_LO  = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;

	logic [1:0]  phase_q, phase_d;
	logic [7:0]  len_hi_q, len_hi_d;
	logic [15:0] payload_left_q, payload_left_d;
	logic [16:0] packet_left_q, packet_left_d;
	logic [1:0]  held_q, held_d;
	logic [15:0] count_q, count_d;

	logic [15:0] len_full;
	logic [16:0] packet_dec;
	logic [15:0] payload_dec;
	logic        term;

	assign len_full    = {len_hi_q, in_byte};
	assign packet_dec  = (packet_left_q != 17'd0) ? packet_left_q - 17'd1 : packet_left_q;
	assign payload_dec = (payload_left_q != 16'd0) ? payload_left_q - 16'd1 : payload_left_q;

	always_comb begin
		phase_d        = phase_q;
		len_hi_d       = len_hi_q;
		payload_left_d = payload_left_q;
		packet_left_d  = packet_left_q;
		held_d         = held_q;
		count_d        = count_q;
		term           = 1'b0;
		res            = '0;
		res.data       = in_byte;
		if (first_of_packet) begin
			held_d         = 2'd0;
			count_d        = 16'd0;
			payload_left_d = 16'd0;
			if (packet_size <= 17'd2) begin
				packet_left_d = 17'd0;
				len_hi_d      = 8'd0;
				res.tail_v    = 1'b1;
				res.tail_kind = nal_eps_pkg::KIND_REJECT;
				phase_d       = PH_IDLE;
			end else begin
				len_hi_d      = in_byte;
				packet_left_d = packet_size - 17'd1;
				phase_d       = PH_LEN_LO;
			end
		end else begin
			unique case (phase_q)
				PH_LEN_LO: begin
					packet_left_d = packet_dec;
					len_hi_d      = in_byte;
					if (len_full == 16'd0 || {1'b0, len_full} > packet_dec) begin
						res.tail_v    = 1'b1;
						res.tail_kind = nal_eps_pkg::KIND_REJECT;
						phase_d       = PH_IDLE;
					end else begin
						payload_left_d = len_full;
						held_d         = 2'd0;
						count_d        = 16'd0;
						phase_d        = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					packet_left_d  = packet_dec;
					payload_left_d = payload_dec;
					if (held_q[1] && in_byte <= nal_eps_pkg::EP_BYTE) begin
						held_d = 2'd0;
						if (in_byte == nal_eps_pkg::EP_BYTE) begin
							// Emulation prevention byte: the two zeros are real data.
							res.zeros = 2'd2;
						end else begin
							// Start code prefix: the NAL ends and the zeros are dropped.
							res.tail_v = 1'b1;
							term       = 1'b1;
						end
					end else if (in_byte == 8'd0) begin
						held_d = held_q + 2'd1;
					end else begin
						res.zeros  = held_q;
						res.byte_v = 1'b1;
						held_d     = 2'd0;
					end
					if (!term && payload_dec == 16'd0) begin
						res.zeros  = res.zeros + held_d;
						held_d     = 2'd0;
						res.tail_v = 1'b1;
					end
					count_d       = count_q + {14'd0, res.zeros} + {15'd0, res.byte_v};
					res.tail_kind = nal_eps_pkg::KIND_END;
					res.count     = count_d;
					if (res.tail_v) begin
						phase_d = PH_IDLE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			len_hi_q       <= 8'd0;
			payload_left_q <= 16'd0;
			packet_left_q  <= 17'd0;
			held_q         <= 2'd0;
			count_q        <= 16'd0;
		end else if (accept) begin
			phase_q        <= phase_d;
			len_hi_q       <= len_hi_d;
			payload_left_q <= payload_left_d;
			packet_left_q  <= packet_left_d;
			held_q         <= held_d;
			count_q        <= count_d;
		end
	end

endmodule

// File: hdl/nal_eps_outbuf.sv
// ----------------------------------------------------------------------------
// NAL emulation prevention strip: output buffer
// Registers one result bundle and hands its words out one per cycle while m_tready is high.
// ----------------------------------------------------------------------------
module nal_eps_outbuf (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  nal_eps_pkg::nal_eps_res_t  res,
	output logic                       ready,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [23:0]                m_tdata,   // out_byte[7:0], byte_count[23:8]
	output logic [1:0]                 m_tuser,   // kind[1:0]
	output logic                       m_tlast
);

	logic [1:0]  zeros_q;
	logic        byte_v_q;
	logic        tail_v_q;
	logic [1:0]  tail_kind_q;
	logic [7:0]  data_q;
	logic [15:0] count_q;

	logic        pop;
	logic        last;
	logic [2:0]  remaining;

	assign remaining = {1'b0, zeros_q} + {2'd0, byte_v_q} + {2'd0, tail_v_q};
	assign m_tvalid  = (remaining != 3'd0);
	assign last      = (remaining == 3'd1);
	assign pop       = m_tvalid && m_tready;
	assign ready     = !m_tvalid || (pop && last);
	assign m_tlast   = last;

	always_comb begin
		m_tdata = '0;
		m_tuser = nal_eps_pkg::KIND_BYTE;
		if (zeros_q == 2'd0) begin
			if (byte_v_q) begin
				m_tdata[7:0] = data_q;
			end else begin
				m_tuser = tail_kind_q;
				if (tail_kind_q == nal_eps_pkg::KIND_END) begin
					m_tdata[23:8] = count_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zeros_q  <= 2'd0;
			byte_v_q <= 1'b0;
			tail_v_q <= 1'b0;
		end else if (load) begin
			zeros_q  <= res.zeros;
			byte_v_q <= res.byte_v;
			tail_v_q <= res.tail_v;
		end else if (pop) begin
			if (zeros_q != 2'd0) begin
				zeros_q <= zeros_q - 2'd1;
			end else if (byte_v_q) begin
				byte_v_q <= 1'b0;
			end else begin
				tail_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tail_kind_q <= res.tail_kind;
			data_q      <= res.data;
			count_q     <= res.count;
		end
	end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NAL emulation prevention strip: testbench
// Sends length-prefixed packets one byte per word and checks every output
// word against a model of the length check, the escape removal and the end
// code detection, under random gaps on the input and random stalls on the
// output.
// ----------------------------------------------------------------------------
module tb;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int HOLD_OFF_CYCLES = 60;
	localparam int DRAIN_CYCLES    = 20;
	localparam int RANDOM_ITEMS    = 50;

	typedef enum logic [1:0] {PARSE_IDLE, PARSE_LEN_LO, PARSE_PAYLOAD} parse_state_t;
	typedef enum logic [1:0] {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_PERIODIC} ready_mode_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data;
		logic [15:0] count;
		logic        last;
	} nal_word_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;    // in_byte[7:0], packet_size[24:8], zero pad
	logic        s_tuser  = 1'b0;  // first_of_packet
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;          // out_byte[7:0], byte_count[23:8]
	logic [1:0]  m_tuser;          // kind[1:0]
	logic        m_tlast;

	// Model state of the stripper.
	parse_state_t parse_st    = PARSE_IDLE;
	logic [15:0]  nal_len     = '0;
	logic [15:0]  payload_rem = '0;
	logic [15:0]  emitted     = '0;
	logic [16:0]  packet_rem  = '0;
	logic [1:0]   held_zeros  = '0;

	nal_word_t    strip_run[$];
	nal_word_t    expected_words[$];

	int unsigned  errors       = 0;
	int unsigned  cycles       = 0;
	int unsigned  parsed_items = 0;
	int unsigned  burst_left   = 0;
	bit           hold_off_req = 1'b0;
	bit           steady_send  = 1'b0;

	nal_emulation_prevention_strip i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("nal_emulation_prevention_strip: mismatch");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		errors++;
		$display("error at cycle %0d: %s", cycles, msg);
	endtask

	function automatic void add_word(input logic [1:0] kind, input logic [7:0] data,
			input logic [15:0] count);
		nal_word_t w;
		w.kind  = kind;
		w.data  = data;
		w.count = count;
		w.last  = 1'b0;
		strip_run.push_back(w);
	endfunction

	function automatic void add_payload(input logic [7:0] data);
		add_word(nal_eps_pkg::KIND_BYTE, data, 16'd0);
		emitted = emitted + 16'd1;
	endfunction

	function automatic void flush_held();
		while (held_zeros != 2'd0) begin
			add_payload(8'd0);
			held_zeros = held_zeros - 2'd1;
		end
	endfunction

	// Works out the words that one accepted input word causes and queues them.
	function automatic void predict_strip(input logic [7:0] data, input logic first,
			input logic [16:0] pkt_size);
		logic      ended;
		nal_word_t w;
		ended = 1'b0;
		strip_run.delete();
		if (first || parse_st != PARSE_IDLE)
			parsed_items++;
		if (first) begin
			held_zeros  = '0;
			emitted     = '0;
			payload_rem = '0;
			if (pkt_size <= 17'd2) begin
				packet_rem = '0;
				nal_len    = '0;
				add_word(nal_eps_pkg::KIND_REJECT, 8'd0, 16'd0);
				parse_st = PARSE_IDLE;
			end else begin
				nal_len    = {8'd0, data};
				packet_rem = pkt_size - 17'd1;
				parse_st   = PARSE_LEN_LO;
			end
		end else if (parse_st == PARSE_LEN_LO) begin
			nal_len = {nal_len[7:0], data};
			if (packet_rem != 17'd0)
				packet_rem = packet_rem - 17'd1;
			if (nal_len == 16'd0 || {1'b0, nal_len} > packet_rem) begin
				add_word(nal_eps_pkg::KIND_REJECT, 8'd0, 16'd0);
				parse_st = PARSE_IDLE;
			end else begin
				payload_rem = nal_len;
				held_zeros  = '0;
				emitted     = '0;
				parse_st    = PARSE_PAYLOAD;
			end
		end else if (parse_st == PARSE_PAYLOAD) begin
			if (packet_rem != 17'd0)
				packet_rem = packet_rem - 17'd1;
			if (payload_rem != 16'd0)
				payload_rem = payload_rem - 16'd1;
			// Two zeros then 00, 01 or 02 is an end code; two zeros then 03 is an escape.
			if (held_zeros >= 2'd2 && data <= nal_eps_pkg::EP_BYTE) begin
				if (data == nal_eps_pkg::EP_BYTE) begin
					flush_held();
				end else begin
					held_zeros = '0;
					add_word(nal_eps_pkg::KIND_END, 8'd0, emitted);
					ended = 1'b1;
				end
			end else if (data == 8'd0) begin
				held_zeros = held_zeros + 2'd1;
			end else begin
				flush_held();
				add_payload(data);
			end
			if (!ended && payload_rem == 16'd0) begin
				flush_held();
				add_word(nal_eps_pkg::KIND_END, 8'd0, emitted);
				ended = 1'b1;
			end
			if (ended)
				parse_st = PARSE_IDLE;
		end
		if (strip_run.size() != 0) begin
			w = strip_run.pop_back();
			w.last = 1'b1;
			strip_run.push_back(w);
			foreach (strip_run[i])
				expected_words.push_back(strip_run[i]);
		end
	endfunction

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_word(input logic [7:0] data, input logic first,
			input logic [16:0] pkt_size);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = 0;
			if (!steady_send && $urandom_range(0, 3) != 0)
				gap = $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= first;
		s_tdata  <= {7'd0, pkt_size, data};
		do @(posedge clk); while (s_tready !== 1'b1);
		predict_strip(data, first, pkt_size);
		@(negedge clk);
	endtask

	// A byte inside a packet; the size field is not read, so it carries junk.
	task automatic send_body(input logic [7:0] data);
		logic [16:0] junk;
		junk = 17'($urandom_range(0, 65537));
		send_word(data, 1'b0, junk);
	endtask

	function automatic logic [7:0] pick_payload();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r < 7)
			return 8'd0;
		if (r < 9)
			return nal_eps_pkg::EP_BYTE;
		if (r < 11)
			return 8'($urandom_range(1, 2));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic test_idle_and_tiny();
		send_body(8'hFF);
		send_word(8'hFF, 1'b1, 17'd0);
		send_word(8'h00, 1'b1, 17'd1);
		send_word(8'h5A, 1'b1, 17'd2);
	endtask

	task automatic test_bad_length();
		send_word(8'h00, 1'b1, 17'd65535);
		send_body(8'h00);
		send_word(8'h00, 1'b1, 17'd4);
		send_body(8'h03);
		send_body(8'h55);
	endtask

	task automatic test_escape_and_flush();
		send_word(8'h00, 1'b1, 17'd8);
		send_body(8'h06);
		send_body(8'h00);
		send_body(8'h00);
		send_body(nal_eps_pkg::EP_BYTE);
		send_body(8'h00);
		send_body(8'h00);
		// Two held zeros, the byte and the end word all come from this last byte.
		send_body(8'h80);
	endtask

	task automatic test_end_code_and_restart();
		send_word(8'hFF, 1'b1, 17'd65537);
		send_body(8'hFF);
		send_body(8'h7F);
		send_word(8'h00, 1'b1, 17'd7);
		send_body(8'h05);
		send_body(8'h11);
		send_body(8'h00);
		send_body(8'h00);
		send_body(8'h02);
		send_body(8'hAA);
	endtask

	// The receiver holds off while a long NAL of plain bytes keeps coming.
	task automatic test_backpressure();
		steady_send  = 1'b1;
		hold_off_req = 1'b1;
		send_word(8'h00, 1'b1, 17'd22);
		send_body(8'd20);
		repeat (20)
			send_body(8'($urandom_range(1, 255)));
		steady_send = 1'b0;
	endtask

	task automatic test_random();
		int unsigned sel, body_len, start;
		logic [16:0] pkt_size;
		logic [15:0] len;
		start = parsed_items;
		while (parsed_items - start < RANDOM_ITEMS) begin
			steady_send = ($urandom_range(0, 4) == 0);
			sel = $urandom_range(0, 19);
			if (sel == 0) begin
				send_word(8'($urandom_range(0, 255)), 1'b1, 17'($urandom_range(0, 2)));
			end else if (sel == 1) begin
				repeat ($urandom_range(1, 3))
					send_body(8'($urandom_range(0, 255)));
			end else begin
				if (sel == 2) begin
					pkt_size = 17'd65535 + 17'($urandom_range(0, 2));
					len      = 16'($urandom_range(1, 65535));
					body_len = 12;
				end else begin
					pkt_size = 17'($urandom_range(3, 24));
					body_len = pkt_size - 2;
					case ($urandom_range(0, 9))
						0:       len = 16'd0;
						1:       len = 16'(pkt_size - 1 + $urandom_range(0, 3));
						default: len = 16'($urandom_range(1, pkt_size - 2));
					endcase
				end
				// Some packets are cut short by the next one.
				if ($urandom_range(0, 3) == 0)
					body_len = $urandom_range(0, body_len);
				send_word(len[15:8], 1'b1, pkt_size);
				send_body(len[7:0]);
				repeat (body_len)
					send_body(pick_payload());
			end
		end
		steady_send = 1'b0;
	endtask

	initial begin : drive_ready
		ready_mode_t mode;
		int unsigned mode_left;
		mode      = READY_ALWAYS;
		mode_left = 0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end
			if (mode_left == 0) begin
				mode      = ready_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 80);
			end
			mode_left--;
			case (mode)
				READY_ALWAYS: m_tready <= 1'b1;
				READY_HALF:   m_tready <= ($urandom_range(0, 1) == 1);
				READY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
				default:      m_tready <= (cycles % 5 != 0);
			endcase
		end
	end

	initial begin : check_words
		nal_word_t got, want;
		bit        seen;
		forever begin
			@(posedge clk);
			seen      = (m_tvalid === 1'b1) && (m_tready === 1'b1);
			got.kind  = m_tuser;
			got.data  = m_tdata[7:0];
			got.count = m_tdata[23:8];
			got.last  = m_tlast;
			@(negedge clk);
			if (seen) begin
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("unexpected word: kind %0d data %02h count %0d last %0b",
						got.kind, got.data, got.count, got.last));
				end else begin
					want = expected_words.pop_front();
					if (got.kind !== want.kind || got.data !== want.data ||
							got.count !== want.count || got.last !== want.last)
						report_mismatch($sformatf(
							"kind %0d/%0d data %02h/%02h count %0d/%0d last %0b/%0b (got/want)",
							got.kind, want.kind, got.data, want.data,
							got.count, want.count, got.last, want.last));
				end
			end
		end
	end

	initial begin : run_tests
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_idle_and_tiny();
		test_bad_length();
		test_escape_and_flush();
		test_end_code_and_restart();
		test_backpressure();
		test_random();
		s_tvalid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("nal_emulation_prevention_strip: match");
		end else begin
			$display("nal_emulation_prevention_strip: mismatch");
		end
		$finish;
	end

endmodule
